// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check, also evaluated during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ghfl_pkg.sv -----
package ghfl_pkg;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned HSlotW  = 9;
  localparam int unsigned HGenW   = 8;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotOutW = 8;
  localparam int unsigned GenOutW = 8;
  localparam int unsigned LiveW   = 9;
  localparam int unsigned CapW    = 9;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ReqW-1:0] REQ_ADD    = 2'd0;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqW-1:0] REQ_GET    = 2'd2;
  localparam logic [ReqW-1:0] REQ_UPDATE = 2'd3;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_CAPACITY  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_GEN = 1'b1;

  localparam logic [CapW-1:0] CAP_RESET = 9'd256;

  // Outcome of one request, handed from the evaluator to the sequencer.
  typedef struct packed {
    logic               mem_we;
    logic [StatusW-1:0] status;
  } ghfl_act_t;

endpackage

// ----- rtl/core/ghfl_exec.sv -----
module ghfl_exec
  import ghfl_pkg::*;
#(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned GEN_BITS   = 8,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned SW = $clog2(SLOTS),
  localparam int unsigned LW = $clog2(SLOTS + 1)
) (
  input  logic [ReqW-1:0]       req_i,
  input  logic [HSlotW-1:0]     hslot_i,
  input  logic [HGenW-1:0]      hgen_i,
  input  logic [VALUE_BITS-1:0] val_i,
  input  logic [LW-1:0]         rd_link_i,
  input  logic [GEN_BITS-1:0]   rd_gen_i,
  input  logic [VALUE_BITS-1:0] rd_val_i,
  input  logic [LW-1:0]         head_i,
  input  logic [LiveW-1:0]      used_i,
  input  logic [CapW-1:0]       cap_i,
  input  logic                  chk_gen_i,
  output ghfl_act_t             act_o,
  output logic [SW-1:0]         wr_addr_o,
  output logic [LW-1:0]         wr_link_o,
  output logic [GEN_BITS-1:0]   wr_gen_o,
  output logic [VALUE_BITS-1:0] wr_val_o,
  output logic [LW-1:0]         head_d_o,
  output logic [LiveW-1:0]      used_d_o,
  output logic [SlotOutW-1:0]   slot_o,
  output logic [GenOutW-1:0]    gen_o,
  output logic [ValW-1:0]       val_o
);

  localparam int unsigned CW = (LW > CapW) ? LW : CapW;
  localparam int unsigned GC = (GEN_BITS > HGenW) ? GEN_BITS : HGenW;

  logic [CW-1:0] cap_eff;
  logic          handle_ok;
  logic          full;

  always_comb begin
    cap_eff   = (CW'(cap_i) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(cap_i);
    handle_ok = (CW'(hslot_i) < cap_eff) &&
                (!chk_gen_i || (GC'(hgen_i) == GC'(rd_gen_i)));
    full      = (CW'(head_i) >= cap_eff) || (CW'(used_i) >= cap_eff);

    act_o.mem_we = 1'b0;
    act_o.status = ST_OK;
    wr_addr_o    = SW'(hslot_i);
    wr_link_o    = rd_link_i;
    wr_gen_o     = rd_gen_i;
    wr_val_o     = rd_val_i;
    head_d_o     = head_i;
    used_d_o     = used_i;
    slot_o       = '0;
    gen_o        = '0;
    val_o        = '0;

    if (req_i == REQ_ADD) begin
      wr_addr_o = SW'(head_i);
      if (full) begin
        act_o.status = ST_FULL;
      end else begin
        act_o.mem_we = 1'b1;
        wr_val_o     = val_i;
        head_d_o     = rd_link_i;
        used_d_o     = used_i + LiveW'(1);
        slot_o       = SlotOutW'(head_i);
        gen_o        = GenOutW'(rd_gen_i);
      end
    end else if (!handle_ok) begin
      act_o.status = ST_INVALID;
    end else begin
      case (req_i)
        REQ_REMOVE: begin
          act_o.mem_we = 1'b1;
          wr_link_o    = head_i;
          wr_gen_o     = rd_gen_i + GEN_BITS'(1);
          head_d_o     = LW'(hslot_i);
          used_d_o     = (used_i != '0) ? used_i - LiveW'(1) : used_i;
          val_o        = ValW'(rd_val_i);
        end
        REQ_GET: begin
          val_o = ValW'(rd_val_i);
        end
        default: begin
          act_o.mem_we = 1'b1;
          wr_val_o     = val_i;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/generational_handle_free_list_unit.sv -----
// Channel   Dir  Word
// s_axis    in   tuser: req_type; tdata: handle_slot, handle_generation, value_in
// m_axis    out  tuser: status; tdata: slot_out, generation_out, value_out, live_count
// cfg       in   cfg_idx_i 0 capacity, 1 check_generation; one write per cycle
//
// Each word is read from the table on accept, then evaluated and written back in ST_EXEC.
// The table is a single-port-read memory; that read-then-write loop sets the rate.
// After reset a clearing pass over all SLOTS entries initialises the table; no words
// are taken meanwhile. Config writes are taken at any time.
// A stalled result is held in the output register; the block takes the next
// word meanwhile and waits in evaluate until the register frees up.
`include "assert_macros.svh"

module generational_handle_free_list_unit
  import ghfl_pkg::*;
#(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned GEN_BITS   = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,  // handle_slot, handle_generation, value_in
  input  logic [ReqW-1:0]      s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // slot_out, generation_out, value_out, live_count
  output logic [StatusW-1:0]   m_axis_tuser,  // status
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CapW-1:0]      cfg_data_i
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [LW-1:0]         link;
    logic [GEN_BITS-1:0]   gen;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

  state_e              state_q;
  logic [SW-1:0]       clr_cnt_q;
  logic [LW-1:0]       head_q;
  logic [LiveW-1:0]    used_q;
  logic [CapW-1:0]     cap_q;
  logic                chk_gen_q;

  logic [ReqW-1:0]       req_q;
  logic [HSlotW-1:0]     hslot_q;
  logic [HGenW-1:0]      hgen_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  out_vld_q;
  logic [StatusW-1:0]    out_status_q;
  logic [SlotOutW-1:0]   out_slot_q;
  logic [GenOutW-1:0]    out_gen_q;
  logic [ValW-1:0]       out_val_q;
  logic [LiveW-1:0]      out_live_q;

  entry_t                mem [SLOTS];
  entry_t                rd_q;

  logic                  in_acc;
  logic                  done;
  logic [SW-1:0]         rd_addr;
  logic                  mem_we;
  logic [SW-1:0]         mem_waddr;
  entry_t                mem_wdata;

  ghfl_act_t             act;
  logic [SW-1:0]         ex_addr;
  logic [LW-1:0]         ex_link;
  logic [GEN_BITS-1:0]   ex_gen;
  logic [VALUE_BITS-1:0] ex_val;
  logic [LW-1:0]         head_d;
  logic [LiveW-1:0]      used_d;
  logic [SlotOutW-1:0]   ex_slot_out;
  logic [GenOutW-1:0]    ex_gen_out;
  logic [ValW-1:0]       ex_val_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign done          = (state_q == ST_EXEC) && (!out_vld_q || m_axis_tready);
  assign rd_addr       = (s_axis_tuser == REQ_ADD) ? SW'(head_q) : SW'(s_axis_tdata[8:0]);

  ghfl_exec #(
    .SLOTS      (SLOTS),
    .GEN_BITS   (GEN_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_exec (
    .req_i     (req_q),
    .hslot_i   (hslot_q),
    .hgen_i    (hgen_q),
    .val_i     (val_q),
    .rd_link_i (rd_q.link),
    .rd_gen_i  (rd_q.gen),
    .rd_val_i  (rd_q.val),
    .head_i    (head_q),
    .used_i    (used_q),
    .cap_i     (cap_q),
    .chk_gen_i (chk_gen_q),
    .act_o     (act),
    .wr_addr_o (ex_addr),
    .wr_link_o (ex_link),
    .wr_gen_o  (ex_gen),
    .wr_val_o  (ex_val),
    .head_d_o  (head_d),
    .used_d_o  (used_d),
    .slot_o    (ex_slot_out),
    .gen_o     (ex_gen_out),
    .val_o     (ex_val_out)
  );

  always_comb begin
    if (state_q == ST_CLR) begin
      mem_we         = 1'b1;
      mem_waddr      = clr_cnt_q;
      mem_wdata.link = LW'(clr_cnt_q) + LW'(1);
      mem_wdata.gen  = '0;
      mem_wdata.val  = '0;
    end else begin
      mem_we         = done && act.mem_we;
      mem_waddr      = ex_addr;
      mem_wdata.link = ex_link;
      mem_wdata.gen  = ex_gen;
      mem_wdata.val  = ex_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      head_q    <= '0;
      used_q    <= '0;
      cap_q     <= CAP_RESET;
      chk_gen_q <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CAPACITY:  cap_q     <= cfg_data_i;
          CFG_CHECK_GEN: chk_gen_q <= cfg_data_i[0];
        endcase
      end

      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLR: begin
          clr_cnt_q <= clr_cnt_q + SW'(1);
          if (clr_cnt_q == SW'(SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_q   <= ST_IDLE;
            head_q    <= head_d;
            used_q    <= used_d;
            out_vld_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= s_axis_tuser;
      hslot_q <= s_axis_tdata[8:0];
      hgen_q  <= s_axis_tdata[16:9];
      val_q   <= VALUE_BITS'(s_axis_tdata[48:17]);
    end
    if (done) begin
      out_status_q <= act.status;
      out_slot_q   <= ex_slot_out;
      out_gen_q    <= ex_gen_out;
      out_val_q    <= ex_val_out;
      out_live_q   <= used_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_live_q, out_val_q, out_gen_q, out_slot_q};

  `ASSERT_CLK(a_acc_to_exec, clk_i, rst_ni, in_acc |=> (state_q == ST_EXEC))
  `ASSERT_CLK(a_out_from_exec, clk_i, rst_ni,
              $rose(out_vld_q) |-> $past(state_q == ST_EXEC))
  `ASSERT_CLK(a_used_bound, clk_i, rst_ni, 32'(used_q) <= SLOTS)
  `ASSERT_CLK(a_head_bound, clk_i, rst_ni, 32'(head_q) <= SLOTS)

endmodule

// ----- sim/handle_table_checker.sv -----
module handle_table_checker
  import ghfl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,  // handle_slot, handle_generation, value_in
  input  logic [ReqW-1:0]    s_axis_tuser,  // req_type
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [63:0]        m_axis_tdata,  // slot_out, generation_out, value_out, live_count
  input  logic [StatusW-1:0] m_axis_tuser,  // status
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CapW-1:0]    cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [SlotOutW-1:0] slot;
    logic [GenOutW-1:0]  gen;
    logic [ValW-1:0]     value;
    logic [LiveW-1:0]    live;
  } answer_t;

  logic [HSlotW-1:0] link_mem [256];
  logic [ValW-1:0]   val_mem  [256];
  logic [HGenW-1:0]  gen_mem  [256];
  logic [HSlotW-1:0] head;
  logic [LiveW-1:0]  used;
  logic [CapW-1:0]   cap;
  logic              gen_check;

  answer_t     awaited_answers [$];
  answer_t     want;
  int unsigned n_errors = 0;

  // Updates the table copy and returns the answer the block owes for this word.
  function automatic answer_t apply_request(input logic [ReqW-1:0] req,
                                            input logic [HSlotW-1:0] hslot,
                                            input logic [HGenW-1:0] hgen,
                                            input logic [ValW-1:0] val);
    answer_t          a;
    logic [CapW-1:0]  lim;
    logic [7:0]       s;
    logic             handle_ok;
    a = '0;
    lim = (cap > 9'd256) ? 9'd256 : cap;
    handle_ok = (hslot < lim) && (!gen_check || hgen == gen_mem[hslot[7:0]]);
    if (req == REQ_ADD) begin
      if (head >= lim || used >= lim) begin
        a.status = ST_FULL;
      end else begin
        s = head[7:0];
        used = used + LiveW'(1);
        head = link_mem[s];
        val_mem[s] = val;
        a.slot = s;
        a.gen = gen_mem[s];
      end
    end else if (!handle_ok) begin
      a.status = ST_INVALID;
    end else if (req == REQ_REMOVE) begin
      s = hslot[7:0];
      if (used != '0) used = used - LiveW'(1);
      link_mem[s] = head;
      head = hslot;
      gen_mem[s] = gen_mem[s] + HGenW'(1);
      a.value = val_mem[s];
    end else if (req == REQ_GET) begin
      a.value = val_mem[hslot[7:0]];
    end else begin
      val_mem[hslot[7:0]] = val;
    end
    a.live = used;
    return a;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        link_mem[i] = 9'(i + 1);
        val_mem[i]  = '0;
        gen_mem[i]  = '0;
      end
      head = '0;
      used = '0;
      cap = CAP_RESET;
      gen_check = 1'b1;
      awaited_answers.delete();
      pending_o <= 0;
      errors_o <= n_errors;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: answer word with none awaited, expected nothing, got status %0d",
                   $time, m_axis_tuser);
          n_errors++;
        end else begin
          want = awaited_answers.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("slot_out", 32'(want.slot), 32'(m_axis_tdata[7:0]));
          check_field("generation_out", 32'(want.gen), 32'(m_axis_tdata[15:8]));
          check_field("value_out", want.value, m_axis_tdata[47:16]);
          check_field("live_count", 32'(want.live), 32'(m_axis_tdata[56:48]));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CAPACITY) cap = cfg_data_i;
        else if (cfg_idx_i == CFG_CHECK_GEN) gen_check = cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_answers.push_back(apply_request(s_axis_tuser, s_axis_tdata[8:0],
                                                s_axis_tdata[16:9], s_axis_tdata[48:17]));
      end
      pending_o <= awaited_answers.size();
      errors_o <= n_errors;
    end
  end

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ghfl_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_OFF   = 4;
  localparam int unsigned TAIL       = 10;

  typedef struct packed {
    logic [HSlotW-1:0] slot;
    logic [HGenW-1:0]  gen;
  } handle_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [55:0]        s_axis_tdata = '0;  // handle_slot, handle_generation, value_in
  logic [ReqW-1:0]    s_axis_tuser = '0;  // req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;       // slot_out, generation_out, value_out, live_count
  logic [StatusW-1:0] m_axis_tuser;       // status
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CapW-1:0]    cfg_data_i = '0;
  int unsigned        pending_w;
  int unsigned        errors_w;

  logic [CapW-1:0]  cur_cap = CAP_RESET;
  logic             cur_check = 1'b1;
  handle_t          live_q [$];
  handle_t          stale_q [$];
  logic [ReqW-1:0]  issued_req_q [$];
  logic [ReqW-1:0]  done_req;
  int unsigned      n_add, n_remove, n_get, n_update, n_settings = 1;
  int unsigned      n_ok, n_full, n_invalid;
  int unsigned      stall_cyc;
  int unsigned      stall_mode;

  generational_handle_free_list_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  handle_table_checker table_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending_w),
    .errors_o      (errors_w)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver back-pressure in one of four randomly picked patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cyc <= 0;
      stall_mode <= 0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 96 == 0) stall_mode <= $urandom_range(3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(1));
        2: m_axis_tready <= ($urandom_range(3) == 0);
        default: m_axis_tready <= stall_cyc[3];
      endcase
    end
  end

  // collect handles handed out by add, for well-formed follow-up words, and tally answer statuses
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready && issued_req_q.size() != 0) begin
      done_req = issued_req_q.pop_front();
      case (m_axis_tuser)
        ST_OK:   n_ok++;
        ST_FULL: n_full++;
        default: n_invalid++;
      endcase
      if (done_req == REQ_ADD && m_axis_tuser == ST_OK)
        live_q.push_back({1'b0, m_axis_tdata[7:0], m_axis_tdata[15:8]});
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  task automatic send_word(input logic [ReqW-1:0] req, input logic [HSlotW-1:0] slot,
                           input logic [HGenW-1:0] gen, input logic [ValW-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {7'd0, val, gen, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    issued_req_q.push_back(req);
    case (req)
      REQ_ADD:    n_add++;
      REQ_REMOVE: n_remove++;
      REQ_GET:    n_get++;
      default:    n_update++;
    endcase
  endtask

  // hold the sender until every answer is back, then settle
  task automatic drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_w != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CapW-1:0] cap, input logic chk);
    drain(HOLD_OFF);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CAPACITY;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CHECK_GEN;
    cfg_data_i <= {{(CapW-1){1'b0}}, chk};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cap = cap;
    cur_check = chk;
    n_settings++;
  endtask

  task automatic random_word(input int unsigned rm_pct);
    int unsigned      pick, k, lim;
    logic [ReqW-1:0]  req;
    logic [HSlotW-1:0] slot;
    logic [HGenW-1:0] gen;
    logic [ValW-1:0]  val;
    handle_t          h;
    lim = (cur_cap > 256) ? 256 : cur_cap;
    case ($urandom_range(7))
      0: val = '0;
      1: val = '1;
      default: val = $urandom();
    endcase
    slot = HSlotW'($urandom_range(511));
    gen = HGenW'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 12) begin
      // noise: any request, random or stale handle
      req = ReqW'($urandom_range(3));
      if (stale_q.size() != 0 && pick < 6) begin
        h = stale_q[$urandom_range(stale_q.size() - 1)];
        slot = h.slot;
        gen = h.gen;
      end
    end else begin
      pick = $urandom_range(99);
      if (pick < rm_pct) req = REQ_REMOVE;
      else if (pick < rm_pct + (100 - rm_pct) / 2) req = REQ_ADD;
      else if (pick[0]) req = REQ_GET;
      else req = REQ_UPDATE;
      if (req != REQ_ADD) begin
        if (!cur_check) begin
          slot = HSlotW'($urandom_range(lim - 1));
        end else if (live_q.size() == 0) begin
          req = REQ_ADD;
        end else begin
          k = $urandom_range(live_q.size() - 1);
          h = live_q[k];
          slot = h.slot;
          gen = h.gen;
          if (req == REQ_REMOVE) begin
            live_q.delete(k);
            stale_q.push_back(h);
            if (stale_q.size() > 32) void'(stale_q.pop_front());
          end
        end
      end
    end
    send_word(req, slot, gen, val);
  endtask

  task automatic random_phase(input logic [CapW-1:0] cap, input logic chk,
                              input int unsigned n, input int unsigned rm_pct,
                              input int unsigned gap_max);
    int          burst;
    int unsigned gap;
    write_regs(cap, chk);
    burst = $urandom_range(20, 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) begin
        drain(1);
      end else if (burst <= 0) begin
        gap = $urandom_range(gap_max);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(20, 1);
      end
      random_word(rm_pct);
      burst--;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full capacity, generations checked
    send_word(REQ_GET, 9'd0, 8'd0, '0);
    send_word(REQ_ADD, 9'd0, 8'd0, 32'hFFFF_FFFF);
    send_word(REQ_ADD, 9'd0, 8'd0, 32'h0000_0000);
    send_word(REQ_UPDATE, 9'd1, 8'd0, 32'hA5A5_A5A5);
    send_word(REQ_GET, 9'd1, 8'd0, '0);
    send_word(REQ_GET, 9'd1, 8'd255, '0);
    send_word(REQ_GET, 9'd511, 8'd0, '1);
    send_word(REQ_UPDATE, 9'd256, 8'd0, 32'h1234_5678);
    send_word(REQ_REMOVE, 9'd0, 8'd0, '0);
    send_word(REQ_REMOVE, 9'd0, 8'd0, '0);
    send_word(REQ_REMOVE, 9'd0, 8'd1, '0);
    send_word(REQ_ADD, 9'd0, 8'd0, 32'h1234_5678);
    send_word(REQ_GET, 9'd0, 8'd2, '0);

    write_regs(9'd1, 1'b1);
    send_word(REQ_ADD, 9'd0, 8'd0, 32'hDEAD_BEEF);
    send_word(REQ_GET, 9'd1, 8'd0, '0);
    send_word(REQ_REMOVE, 9'd0, 8'd2, '0);
    send_word(REQ_ADD, 9'd0, 8'd0, 32'h8000_0001);

    write_regs(9'd0, 1'b1);
    send_word(REQ_ADD, 9'd0, 8'd0, 32'h0000_0001);
    send_word(REQ_GET, 9'd0, 8'd3, '0);
    send_word(REQ_REMOVE, 9'd0, 8'd3, '0);

    write_regs(9'd256, 1'b0);
    send_word(REQ_GET, 9'd5, 8'd200, '0);
    send_word(REQ_UPDATE, 9'd300, 8'd7, 32'h7FFF_FFFF);
    send_word(REQ_REMOVE, 9'd1, 8'd99, '0);

    random_phase(9'd2, 1'b1, 200, 30, 6);
    random_phase(9'd1, 1'b0, 350, 85, 3);
    random_phase(9'd256, 1'b1, 250, 25, 0);
    random_phase(9'd511, 1'b0, 150, 30, 6);
    random_phase(9'd17, 1'b1, 250, 35, 4);
    random_phase(9'd300, 1'b1, 200, 40, 2);

    drain(TAIL);
    $display("covered %0d requests (%0d add, %0d remove, %0d get, %0d update) over %0d settings",
             n_add + n_remove + n_get + n_update, n_add, n_remove, n_get, n_update, n_settings);
    $display("answers seen: %0d ok, %0d table full, %0d invalid handle",
             n_ok, n_full, n_invalid);
    if (errors_w == 0 && pending_w == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- generational_handle_free_list_unit.f -----
+incdir+rtl/core
rtl/core/ghfl_pkg.sv
rtl/core/ghfl_exec.sv
rtl/core/generational_handle_free_list_unit.sv
sim/handle_table_checker.sv
sim/tb.sv
